@@ design/h2r_pkg.sv @@
// shared widths, fixed-point constants and types for the hsl to rgb converter
package h2r_pkg;

   // fixed-point format of all fractions
   localparam int FRAC_BITS = 16;

   // transaction field widths
   localparam int HUE_W  = 14;
   localparam int SAT_W  = 14;
   localparam int LIT_W  = 7;
   localparam int CHAN_W = 8;

   // input scales and channel full scale
   localparam int PCT_SCALE = 10000;
   localparam int LIT_SCALE = 100;
   localparam int CHAN_FULL = 255;

   localparam logic [HUE_W-1:0]  HUE_MAX  = HUE_W'(PCT_SCALE);
   localparam logic [SAT_W-1:0]  SAT_MAX  = SAT_W'(PCT_SCALE);
   localparam logic [LIT_W-1:0]  LIT_MAX  = LIT_W'(LIT_SCALE);
   localparam logic [CHAN_W-1:0] CHAN_MAX = CHAN_W'(CHAN_FULL);

   // reciprocal scaling for the constant divides
   localparam int RCP_SHIFT = 14;
   localparam int HS_RCP_W  = FRAC_BITS + 1;
   localparam int LT_RCP_W  = FRAC_BITS + 8;
   localparam int QP_W      = HUE_W + HS_RCP_W;
   localparam int REM_W     = FRAC_BITS + HUE_W + 1;

   localparam logic [63:0] ONE_64 = 64'd1 << FRAC_BITS;

   localparam logic [HS_RCP_W-1:0] HS_RCP =
      HS_RCP_W'((64'd1 << (FRAC_BITS + RCP_SHIFT)) / 64'(PCT_SCALE));
   localparam logic [LT_RCP_W-1:0] LT_RCP =
      LT_RCP_W'((64'd1 << (FRAC_BITS + RCP_SHIFT)) / 64'(LIT_SCALE));

   // datapath widths
   localparam int FX_W   = FRAC_BITS + 1;
   localparam int V_W    = FRAC_BITS + 2;
   localparam int SV_W   = FRAC_BITS + 4;
   localparam int PROD_W = V_W + FX_W;
   localparam int SIX_W  = PROD_W + 3;
   localparam int VAL_W  = FRAC_BITS + 7;
   localparam int CH_W   = VAL_W + CHAN_W;

   localparam logic [FX_W-1:0] FX_ONE        = FX_W'(ONE_64);
   localparam logic [FX_W-1:0] FX_THIRD      = FX_W'(ONE_64 / 3);
   localparam logic [FX_W-1:0] FX_TWO_THIRDS = FX_W'((2 * ONE_64) / 3);

   localparam int NUM_STAGES = 8;
   localparam int NUM_CHAN   = 3;

   // piece of the hue function a channel falls in
   typedef enum logic [1:0] {
      SEG_RISE,
      SEG_TOP,
      SEG_FALL,
      SEG_BOTTOM
   } seg_type;

endpackage

@@ design/h2r_if.sv @@
// valid/ready channel interfaces for hsl requests and rgb responses
interface h2r_req_if import h2r_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [HUE_W-1:0] hue;
   logic [SAT_W-1:0] saturation;
   logic [LIT_W-1:0] lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);
endinterface

interface h2r_rsp_if import h2r_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ design/hsl_to_rgb_converter.sv @@
// hsl to 8-bit rgb colour converter, eight-stage pipeline
//
//   channel      dir   handshake      payload
//   req_channel  in    valid/ready    hue[13:0] saturation[13:0] lightness[6:0]
//   rsp_channel  out   valid/ready    red[7:0] green[7:0] blue[7:0]
//
// one transaction per clock sustained while the response side is ready; each
// transaction passes through the eight register stages (input clamp, scale, divide
// fixup, l*s multiply, v1/v2 and hue wrap, d*t multiply, select, 255 scaling)
// synchronous active-high reset clears only the stage valid bits
// a stage holds while its successor is full and stalled; empty stages still
// load, so bubbles close up and input is taken while a result waits
module hsl_to_rgb_converter import h2r_pkg::*; (
   input logic       clock,
   input logic       reset,
   h2r_req_if.sink   req_channel,
   h2r_rsp_if.source rsp_channel
);

   // signed views of the fixed-point constants
   localparam logic signed [SV_W-1:0] S_ONE        = SV_W'(FX_ONE);
   localparam logic signed [SV_W-1:0] S_TWO_ONE    = SV_W'(FX_ONE) <<< 1;
   localparam logic signed [SV_W-1:0] S_THIRD      = SV_W'(FX_THIRD);
   localparam logic signed [SV_W-1:0] S_TWO_THIRDS = SV_W'(FX_TWO_THIRDS);
   localparam logic signed [SV_W-1:0] S_TWO        = SV_W'(2);
   localparam logic signed [SV_W-1:0] S_THREE      = SV_W'(3);
   localparam logic signed [SV_W-1:0] S_SIX        = SV_W'(6);

   // stage valid bits and per-stage load enables
   logic [NUM_STAGES-1:0] vld_ff, vld_in, adv;

   // stage 1: clamped inputs
   logic [HUE_W-1:0] s1_hue_ff, s1_hue_in;
   logic [SAT_W-1:0] s1_sat_ff, s1_sat_in;
   logic [LIT_W-1:0] s1_lit_ff, s1_lit_in;
   logic             s1_white_ff, s1_white_in;

   // stage 2: reciprocal quotient estimates
   logic [HUE_W-1:0] s2_hue_ff;
   logic [SAT_W-1:0] s2_sat_ff;
   logic [LIT_W-1:0] s2_lit_ff;
   logic [FX_W-1:0]  s2_hq_ff, s2_hq_in;
   logic [FX_W-1:0]  s2_sq_ff, s2_sq_in;
   logic [FX_W-1:0]  s2_lq_ff, s2_lq_in;
   logic             s2_white_ff;

   // stage 3: exact fixed-point h, s, l
   logic [FX_W-1:0]  s3_h_ff, s3_h_in;
   logic [FX_W-1:0]  s3_s_ff, s3_s_in;
   logic [FX_W-1:0]  s3_l_ff, s3_l_in;
   logic             s3_white_ff;
   logic [REM_W-1:0] hrem, srem, lrem;

   // stage 4: l*s product
   logic [FX_W-1:0]   s4_h_ff, s4_s_ff, s4_l_ff;
   logic [FX_W-1:0]   s4_p_ff, s4_p_in;
   logic              s4_white_ff;
   logic [2*FX_W-1:0] ls_full;

   // stage 5: v1, v2, d and per-channel hue segment
   logic [V_W-1:0]  s5_v1_ff, s5_v1_in;
   logic [V_W-1:0]  s5_v2_ff, s5_v2_in;
   logic [V_W-1:0]  s5_d_ff, s5_d_in;
   logic [FX_W-1:0] s5_t_ff [NUM_CHAN];
   logic [FX_W-1:0] s5_t_in [NUM_CHAN];
   seg_type         s5_seg_ff [NUM_CHAN];
   seg_type         s5_seg_in [NUM_CHAN];
   logic            s5_white_ff;

   logic signed [SV_W-1:0] l_sx, s_sx, p_sx, h_sx, v1_sx, v2_sx, d_sx;
   logic signed [SV_W-1:0] vh_sx [NUM_CHAN];
   logic signed [SV_W-1:0] tf_sx [NUM_CHAN];

   // stage 6: d*t products
   logic [PROD_W-1:0] s6_prod_ff [NUM_CHAN];
   logic [PROD_W-1:0] s6_prod_in [NUM_CHAN];
   seg_type           s6_seg_ff [NUM_CHAN];
   logic [V_W-1:0]    s6_v1_ff, s6_v2_ff;
   logic              s6_white_ff;

   // stage 7: hue function values
   logic [VAL_W-1:0] s7_val_ff [NUM_CHAN];
   logic [VAL_W-1:0] s7_val_in [NUM_CHAN];
   logic [SIX_W-1:0] six_w [NUM_CHAN];
   logic             s7_white_ff;

   // stage 8: output channels
   logic [CHAN_W-1:0] s8_chan_ff [NUM_CHAN];
   logic [CHAN_W-1:0] s8_chan_in [NUM_CHAN];
   logic [CH_W-1:0]   scaled [NUM_CHAN];

   // a stage may load when it is empty or its successor loads
   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_channel.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      vld_in[0] = adv[0] ? req_channel.valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_channel.ready = adv[0];
   assign rsp_channel.valid = vld_ff[NUM_STAGES-1];
   assign rsp_channel.red   = s8_chan_ff[0];
   assign rsp_channel.green = s8_chan_ff[1];
   assign rsp_channel.blue  = s8_chan_ff[2];

   // stage 1: saturate out-of-range inputs, zero saturation means white
   always_comb begin
      s1_hue_in   = (req_channel.hue > HUE_MAX) ? HUE_MAX : req_channel.hue;
      s1_sat_in   = (req_channel.saturation > SAT_MAX) ? SAT_MAX : req_channel.saturation;
      s1_lit_in   = (req_channel.lightness > LIT_MAX) ? LIT_MAX : req_channel.lightness;
      s1_white_in = (req_channel.saturation == '0);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_hue_ff   <= s1_hue_in;
         s1_sat_ff   <= s1_sat_in;
         s1_lit_ff   <= s1_lit_in;
         s1_white_ff <= s1_white_in;
      end
   end

   // stage 2: x*ONE/scale estimated by a reciprocal, low by at most one
   always_comb begin
      s2_hq_in = FX_W'((QP_W'(s1_hue_ff) * QP_W'(HS_RCP)) >> RCP_SHIFT);
      s2_sq_in = FX_W'((QP_W'(s1_sat_ff) * QP_W'(HS_RCP)) >> RCP_SHIFT);
      s2_lq_in = FX_W'((QP_W'(s1_lit_ff) * QP_W'(LT_RCP)) >> RCP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_hue_ff   <= s1_hue_ff;
         s2_sat_ff   <= s1_sat_ff;
         s2_lit_ff   <= s1_lit_ff;
         s2_hq_ff    <= s2_hq_in;
         s2_sq_ff    <= s2_sq_in;
         s2_lq_ff    <= s2_lq_in;
         s2_white_ff <= s1_white_ff;
      end
   end

   // stage 3: remainder check bumps the estimate to the exact floor
   always_comb begin
      hrem = (REM_W'(s2_hue_ff) << FRAC_BITS) - REM_W'(s2_hq_ff) * REM_W'(PCT_SCALE);
      srem = (REM_W'(s2_sat_ff) << FRAC_BITS) - REM_W'(s2_sq_ff) * REM_W'(PCT_SCALE);
      lrem = (REM_W'(s2_lit_ff) << FRAC_BITS) - REM_W'(s2_lq_ff) * REM_W'(LIT_SCALE);
      s3_h_in = (hrem >= REM_W'(PCT_SCALE)) ? s2_hq_ff + FX_W'(1) : s2_hq_ff;
      s3_s_in = (srem >= REM_W'(PCT_SCALE)) ? s2_sq_ff + FX_W'(1) : s2_sq_ff;
      s3_l_in = (lrem >= REM_W'(LIT_SCALE)) ? s2_lq_ff + FX_W'(1) : s2_lq_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_h_ff     <= s3_h_in;
         s3_s_ff     <= s3_s_in;
         s3_l_ff     <= s3_l_in;
         s3_white_ff <= s2_white_ff;
      end
   end

   // stage 4: floor(l*s); l*(1+s) is l plus this term
   always_comb begin
      ls_full = (2*FX_W)'(s3_l_ff) * (2*FX_W)'(s3_s_ff);
      s4_p_in = ls_full[FRAC_BITS +: FX_W];
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_h_ff     <= s3_h_ff;
         s4_s_ff     <= s3_s_ff;
         s4_l_ff     <= s3_l_ff;
         s4_p_ff     <= s4_p_in;
         s4_white_ff <= s3_white_ff;
      end
   end

   // stage 5: v2, v1, d and the hue segment of each channel
   always_comb begin
      l_sx = SV_W'(s4_l_ff);
      s_sx = SV_W'(s4_s_ff);
      p_sx = SV_W'(s4_p_ff);
      h_sx = SV_W'(s4_h_ff);

      if ((l_sx <<< 1) < S_ONE) begin
         v2_sx = l_sx + p_sx;
      end else begin
         v2_sx = l_sx + s_sx - p_sx;
      end
      v1_sx = (l_sx <<< 1) - v2_sx;
      if (v1_sx < 0) begin
         v1_sx = '0;
      end
      d_sx = v2_sx - v1_sx;
      if (d_sx < 0) begin
         d_sx = '0;
      end
      s5_v1_in = V_W'(v1_sx);
      s5_v2_in = V_W'(v2_sx);
      s5_d_in  = V_W'(d_sx);

      // red at h+1/3, green at h, blue at h-1/3
      vh_sx[0] = h_sx + S_THIRD;
      vh_sx[1] = h_sx;
      vh_sx[2] = h_sx - S_THIRD;

      for (int c = 0; c < NUM_CHAN; c++) begin
         // wrap into 0..ONE, exactly ONE stays
         if (vh_sx[c] < 0) begin
            vh_sx[c] = vh_sx[c] + S_ONE;
         end else if (vh_sx[c] > S_ONE) begin
            vh_sx[c] = vh_sx[c] - S_ONE;
         end
         tf_sx[c] = S_TWO_THIRDS - vh_sx[c];
         if (tf_sx[c] < 0) begin
            tf_sx[c] = '0;
         end
         priority if (vh_sx[c] * S_SIX < S_ONE) begin
            s5_seg_in[c] = SEG_RISE;
            s5_t_in[c]   = FX_W'(vh_sx[c]);
         end else if (vh_sx[c] * S_TWO < S_ONE) begin
            s5_seg_in[c] = SEG_TOP;
            s5_t_in[c]   = '0;
         end else if (vh_sx[c] * S_THREE < S_TWO_ONE) begin
            s5_seg_in[c] = SEG_FALL;
            s5_t_in[c]   = FX_W'(tf_sx[c]);
         end else begin
            s5_seg_in[c] = SEG_BOTTOM;
            s5_t_in[c]   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_v1_ff    <= s5_v1_in;
         s5_v2_ff    <= s5_v2_in;
         s5_d_ff     <= s5_d_in;
         s5_t_ff     <= s5_t_in;
         s5_seg_ff   <= s5_seg_in;
         s5_white_ff <= s4_white_ff;
      end
   end

   // stage 6: one d*t multiplier per channel
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         s6_prod_in[c] = PROD_W'(s5_d_ff) * PROD_W'(s5_t_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_prod_ff  <= s6_prod_in;
         s6_seg_ff   <= s5_seg_ff;
         s6_v1_ff    <= s5_v1_ff;
         s6_v2_ff    <= s5_v2_ff;
         s6_white_ff <= s5_white_ff;
      end
   end

   // stage 7: piecewise hue function value
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         six_w[c] = SIX_W'(s6_prod_ff[c]) * SIX_W'(6);
         unique case (s6_seg_ff[c])
            SEG_RISE, SEG_FALL: begin
               s7_val_in[c] = VAL_W'(s6_v1_ff) + VAL_W'(six_w[c] >> FRAC_BITS);
            end
            SEG_TOP: begin
               s7_val_in[c] = VAL_W'(s6_v2_ff);
            end
            SEG_BOTTOM: begin
               s7_val_in[c] = VAL_W'(s6_v1_ff);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s7_val_ff   <= s7_val_in;
         s7_white_ff <= s6_white_ff;
      end
   end

   // stage 8: scale by 255, truncate and saturate; white forces full scale
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         scaled[c] = (CH_W'(s7_val_ff[c]) * CH_W'(CHAN_FULL)) >> FRAC_BITS;
         if (s7_white_ff || (scaled[c] > CH_W'(CHAN_MAX))) begin
            s8_chan_in[c] = CHAN_MAX;
         end else begin
            s8_chan_in[c] = scaled[c][CHAN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s8_chan_ff <= s8_chan_in;
      end
   end

endmodule

@@ design/h2r_checker.sv @@
// port-level assertions for the hsl to rgb converter and their bind
module h2r_checker import h2r_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAN_W-1:0] rsp_red,
   input logic [CHAN_W-1:0] rsp_green,
   input logic [CHAN_W-1:0] rsp_blue
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its colour
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))
      else $error("response payload changed while stalled");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // with the output stage free the whole pipe can move
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output stage");

   // a taken response frees room for a new request
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side drains");

endmodule

bind hsl_to_rgb_converter h2r_checker u_h2r_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_channel.ready),
   .rsp_valid (rsp_channel.valid),
   .rsp_ready (rsp_channel.ready),
   .rsp_red   (rsp_channel.red),
   .rsp_green (rsp_channel.green),
   .rsp_blue  (rsp_channel.blue)
);

@@ test/hsl_to_rgb_converter_tb.sv @@
// self-checking testbench for the hsl to rgb converter: directed corners, then random traffic
module hsl_to_rgb_converter_tb import h2r_pkg::*; ();

   // generous ceiling: ~700 transactions, each worst case a long sender gap,
   // a long receiver stall and the pipe depth, taken several times over
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 4 * NUM_STAGES;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   logic clock = 1'b0;
   logic reset;

   h2r_req_if req_if ();
   h2r_rsp_if rsp_if ();

   hsl_to_rgb_converter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_if),
      .rsp_channel (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // colours still owed by the pipe, oldest first
   rgb_type pending_rgb[$];
   int   mismatch_count = 0;
   int   cycle_count    = 0;
   // when set, neither side inserts gaps or stalls
   bit   no_idle        = 1'b0;

   // ------------------------------------------------------------------
   // color math, done in plain 64-bit signed fixed point
   // ------------------------------------------------------------------

   // piecewise hue function for one channel, vh already offset by +/- a third
   function automatic longint hue_level(input longint v1, input longint v2,
                                        input longint vh_in);
      longint one;
      longint two_thirds;
      longint d;
      longint t;
      longint vh;
      one        = longint'(1) << FRAC_BITS;
      two_thirds = (2 * one) / 3;
      d          = v2 - v1;
      vh         = vh_in;
      if (d < 0) d = 0;
      // wrap into 0..one; exactly one stays put and lands in the flat bottom piece
      if (vh < 0) vh += one;
      if (vh > one) vh -= one;
      if (6 * vh < one) return v1 + ((d * 6 * vh) >>> FRAC_BITS);
      if (2 * vh < one) return v2;
      if (3 * vh < 2 * one) begin
         t = two_thirds - vh;
         if (t < 0) t = 0;
         return v1 + ((d * t * 6) >>> FRAC_BITS);
      end
      return v1;
   endfunction

   // scale a fraction to 0..255, truncating, clipped at full scale
   function automatic logic [CHAN_W-1:0] level_to_chan(input longint v_in);
      longint v;
      longint c;
      v = (v_in < 0) ? 0 : v_in;
      c = (longint'(CHAN_FULL) * v) >>> FRAC_BITS;
      if (c > CHAN_FULL) c = CHAN_FULL;
      return CHAN_W'(c);
   endfunction

   function automatic rgb_type rgb_from_hsl(input logic [HUE_W-1:0] hue,
                                            input logic [SAT_W-1:0] sat,
                                            input logic [LIT_W-1:0] lit);
      rgb_type rgb;
      longint one;
      longint third;
      longint h;
      longint s;
      longint l;
      longint v1;
      longint v2;
      logic [HUE_W-1:0] hue_c;
      logic [SAT_W-1:0] sat_c;
      logic [LIT_W-1:0] lit_c;
      one = longint'(1) << FRAC_BITS;
      // zero saturation short-circuits to white, before any clamping
      if (sat == '0) begin
         rgb.red   = CHAN_MAX;
         rgb.green = CHAN_MAX;
         rgb.blue  = CHAN_MAX;
         return rgb;
      end
      // out-of-range inputs saturate to full scale
      hue_c = (hue > HUE_MAX) ? HUE_MAX : hue;
      sat_c = (sat > SAT_MAX) ? SAT_MAX : sat;
      lit_c = (lit > LIT_MAX) ? LIT_MAX : lit;
      h = longint'(hue_c) * one / PCT_SCALE;
      s = longint'(sat_c) * one / PCT_SCALE;
      l = longint'(lit_c) * one / LIT_SCALE;
      // v2 switches formula at half lightness
      if (2 * l < one) v2 = (l * (one + s)) >>> FRAC_BITS;
      else             v2 = l + s - ((l * s) >>> FRAC_BITS);
      v1 = 2 * l - v2;
      if (v1 < 0) v1 = 0;
      third     = one / 3;
      rgb.red   = level_to_chan(hue_level(v1, v2, h + third));
      rgb.green = level_to_chan(hue_level(v1, v2, h));
      rgb.blue  = level_to_chan(hue_level(v1, v2, h - third));
      return rgb;
   endfunction

   // ------------------------------------------------------------------
   // idle pattern shared by both sides: mostly none or short, now and then long
   // ------------------------------------------------------------------
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // present one colour and hold it until the pipe takes it; valid is left
   // high so that a back-to-back transaction never drops it for a step
   task automatic send_color(input logic [HUE_W-1:0] hue,
                             input logic [SAT_W-1:0] sat,
                             input logic [LIT_W-1:0] lit);
      req_if.valid      <= 1'b1;
      req_if.hue        <= hue;
      req_if.saturation <= sat;
      req_if.lightness  <= lit;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_rgb.push_back(rgb_from_hsl(hue, sat, lit));
   endtask

   // drop valid between transactions; n of zero leaves it high
   task automatic hold_off(input int n);
      if (n > 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_with_gap(input logic [HUE_W-1:0] hue,
                                input logic [SAT_W-1:0] sat,
                                input logic [LIT_W-1:0] lit);
      send_color(hue, sat, lit);
      hold_off(idle_length());
   endtask

   // mostly legal colours, some achromatic, some with raw out-of-range bits
   task automatic send_random_color();
      int mode;
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] sat;
      logic [LIT_W-1:0] lit;
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
         hue = HUE_W'($urandom_range(0, PCT_SCALE));
         sat = SAT_W'($urandom_range(1, PCT_SCALE));
         lit = LIT_W'($urandom_range(0, LIT_SCALE));
      end else if (mode < 80) begin
         hue = HUE_W'($urandom());
         sat = '0;
         lit = LIT_W'($urandom());
      end else begin
         hue = HUE_W'($urandom());
         sat = SAT_W'($urandom());
         lit = LIT_W'($urandom());
      end
      send_with_gap(hue, sat, lit);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   task automatic test_directed_corners();
      // achromatic inputs, including all-ones on the other fields
      send_with_gap(14'd0,     14'd0,     7'd0);
      send_with_gap(14'd10000, 14'd0,     7'd100);
      send_with_gap(14'd16383, 14'd0,     7'd127);
      // primaries and the full-circle hue, where green sits exactly at one
      send_with_gap(14'd0,     14'd10000, 7'd50);
      send_with_gap(14'd3333,  14'd10000, 7'd50);
      send_with_gap(14'd6667,  14'd10000, 7'd50);
      send_with_gap(14'd10000, 14'd10000, 7'd50);
      // hue and saturation above range
      send_with_gap(14'd16383, 14'd10000, 7'd50);
      send_with_gap(14'd0,     14'd16383, 7'd50);
      // hue segment boundaries
      send_with_gap(14'd1667,  14'd10000, 7'd50);
      send_with_gap(14'd5000,  14'd10000, 7'd50);
      send_with_gap(14'd8333,  14'd10000, 7'd50);
      // black, white by lightness, lightness above range
      send_with_gap(14'd2000,  14'd10000, 7'd0);
      send_with_gap(14'd2000,  14'd10000, 7'd100);
      send_with_gap(14'd2000,  14'd5000,  7'd127);
      // either side of the half-lightness switch
      send_with_gap(14'd4000,  14'd5000,  7'd49);
      send_with_gap(14'd4000,  14'd5000,  7'd50);
      send_with_gap(14'd4000,  14'd5000,  7'd51);
      // smallest non-zero values, near-max values, all ones, top bits alone
      send_with_gap(14'd1234,  14'd1,     7'd1);
      send_with_gap(14'd9999,  14'd9999,  7'd99);
      send_with_gap(14'd16383, 14'd16383, 7'd127);
      send_with_gap(14'd8192,  14'd8192,  7'd64);
   endtask

   // full rate on both sides
   task automatic test_back_to_back(input int count);
      no_idle = 1'b1;
      repeat (count) send_random_color();
      no_idle = 1'b0;
   endtask

   task automatic test_random_gaps(input int count);
      repeat (count) send_random_color();
   endtask

   // sender stops until the pipe has fully drained, then restarts
   task automatic test_drain_and_restart(input int count);
      hold_off(1);
      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (count) send_random_color();
   endtask

   // ------------------------------------------------------------------
   // response side: random stalls on ready
   // ------------------------------------------------------------------
   initial begin : rsp_stall
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_length();
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // ------------------------------------------------------------------
   // result check: every accepted response against the oldest owed colour
   // ------------------------------------------------------------------
   rgb_type owed_rgb;
   rgb_type seen_rgb;

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen_rgb.red   = rsp_if.red;
         seen_rgb.green = rsp_if.green;
         seen_rgb.blue  = rsp_if.blue;
         if (pending_rgb.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response r=%0d g=%0d b=%0d at cycle %0d",
                        seen_rgb.red, seen_rgb.green, seen_rgb.blue, cycle_count);
         end else begin
            owed_rgb = pending_rgb.pop_front();
            if (seen_rgb.red   !== owed_rgb.red   ||
                seen_rgb.green !== owed_rgb.green ||
                seen_rgb.blue  !== owed_rgb.blue) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("rgb mismatch at cycle %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                           cycle_count, owed_rgb.red, owed_rgb.green, owed_rgb.blue,
                           seen_rgb.red, seen_rgb.green, seen_rgb.blue);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hsl_to_rgb_converter test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.hue        <= '0;
      req_if.saturation <= '0;
      req_if.lightness  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_back_to_back(200);
      test_random_gaps(380);
      test_drain_and_restart(100);

      // everything handed over; wait for the pipe to give it all back
      hold_off(1);
      while (pending_rgb.size() != 0) @(posedge clock);
      // stray results after the last owed one would show up here
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_rgb.size() == 0) begin
         $display("hsl_to_rgb_converter test passed");
      end else begin
         $display("hsl_to_rgb_converter test failed");
      end
      $finish;
   end

endmodule
